@@ sv/tcog_pkg.sv @@
// shared types and constants of the range guard: item, state and register layouts
// margins, stop reason codes and register indexes; no dependencies
package tcog_pkg;

	// margins around the calibrated floor distance
	localparam int NEAR_MARGIN_PCT   = 15;
	localparam int NEAR_MARGIN_MM    = 30;
	localparam int FAR_MARGIN_PCT    = 20;
	localparam int FAR_MARGIN_MM     = 40;
	localparam int DEVIATION_JUMP_MM = 60;
	localparam int CLIFF_NEAR_MAX_MM = 200;

	// scaled reciprocal for x * pct / 100, exact for 11-bit x
	localparam int PCT_SHIFT = 20;
	localparam int NEAR_MUL  = ((100 - NEAR_MARGIN_PCT) * (2 ** PCT_SHIFT) + 99) / 100;
	localparam int FAR_MUL   = ((100 + FAR_MARGIN_PCT) * (2 ** PCT_SHIFT) + 99) / 100;

	// failed measurement streak limits
	localparam logic [3:0] LOST_STREAK = 4'd4;
	localparam logic [3:0] OBST_STREAK = 4'd8;

	// register indexes
	localparam logic [2:0] REG_CAL_REF     = 3'd0;
	localparam logic [2:0] REG_MAX_VALID   = 3'd1;
	localparam logic [2:0] REG_OBST_STOP   = 3'd2;
	localparam logic [2:0] REG_CLIFF_VOID  = 3'd3;
	localparam logic [2:0] REG_FLOOR_MAX   = 3'd4;
	localparam logic [2:0] REG_APPROACH    = 3'd5;
	localparam logic [2:0] REG_CLIFF_JUMP  = 3'd6;
	localparam logic [2:0] REG_GRACE       = 3'd7;

	typedef enum logic [2:0] {
		RSN_NONE     = 3'd0,
		RSN_OBSTACLE = 3'd1,
		RSN_FLOOR    = 3'd2,
		RSN_FAR      = 3'd3,
		RSN_JUMP     = 3'd4,
		RSN_LOST     = 3'd5
	} reason_t;

	typedef struct packed {
		logic        moving;
		logic        left_reverse;
		logic        right_reverse;
		logic        front_fresh;
		logic        front_valid;
		logic [12:0] front_distance;
		logic        rear_fresh;
		logic        rear_valid;
		logic [12:0] rear_distance;
	} item_t;

	typedef struct packed {
		logic [10:0] cal_ref_mm;
		logic [12:0] max_valid_mm;
		logic [10:0] obstacle_stop_mm;
		logic [12:0] cliff_void_mm;
		logic [10:0] cliff_floor_max_mm;
		logic [10:0] approach_step_mm;
		logic [10:0] cliff_jump_mm;
		logic [7:0]  grace_ticks;
		logic [12:0] near_mm;
		logic [12:0] far_mm;
	} cfg_t;

	typedef struct packed {
		logic        in_motion;
		logic [7:0]  ticks_since_start;
		logic [12:0] last_distance;
		logic        last_valid;
		logic [12:0] least_distance;
		logic        least_valid;
		logic [3:0]  fail_streak;
	} state_t;

endpackage

@@ sv/tcog_cfg_regs.sv @@
// configuration registers of the range guard, with the calibrated near and far
// limits worked out when the calibration reference is written; uses tcog_pkg
module tcog_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [12:0]   wr_data,
	output tcog_pkg::cfg_t cfg
);
	import tcog_pkg::*;

	cfg_t        cfg_q;
	logic [10:0] cal_new;
	logic [32:0] near_prod;
	logic [32:0] far_prod;
	logic [12:0] near_pct;
	logic [12:0] far_pct;
	logic [12:0] near_abs;
	logic [12:0] far_abs;
	logic [12:0] near_new;
	logic [12:0] far_new;

	// limits from the new reference: max of pct and mm below, min of pct and mm above
	assign cal_new   = wr_data[10:0];
	assign near_prod = 33'(cal_new) * 33'(NEAR_MUL);
	assign far_prod  = 33'(cal_new) * 33'(FAR_MUL);
	assign near_pct  = near_prod[PCT_SHIFT +: 13];
	assign far_pct   = far_prod[PCT_SHIFT +: 13];
	assign near_abs  = (cal_new >= 11'(NEAR_MARGIN_MM)) ?
		13'(cal_new) - 13'(NEAR_MARGIN_MM) : 13'd0;
	assign far_abs   = 13'(cal_new) + 13'(FAR_MARGIN_MM);
	assign near_new  = (near_pct > near_abs) ? near_pct : near_abs;
	assign far_new   = (far_pct < far_abs) ? far_pct : far_abs;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_ref_mm         <= 11'd0;
			cfg_q.max_valid_mm       <= 13'd2000;
			cfg_q.obstacle_stop_mm   <= 11'd120;
			cfg_q.cliff_void_mm      <= 13'd400;
			cfg_q.cliff_floor_max_mm <= 11'd60;
			cfg_q.approach_step_mm   <= 11'd30;
			cfg_q.cliff_jump_mm      <= 11'd100;
			cfg_q.grace_ticks        <= 8'd5;
			cfg_q.near_mm            <= 13'd0;
			cfg_q.far_mm             <= 13'd0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CAL_REF: begin
					cfg_q.cal_ref_mm <= cal_new;
					cfg_q.near_mm    <= near_new;
					cfg_q.far_mm     <= far_new;
				end
				REG_MAX_VALID:  cfg_q.max_valid_mm       <= wr_data;
				REG_OBST_STOP:  cfg_q.obstacle_stop_mm   <= wr_data[10:0];
				REG_CLIFF_VOID: cfg_q.cliff_void_mm      <= wr_data;
				REG_FLOOR_MAX:  cfg_q.cliff_floor_max_mm <= wr_data[10:0];
				REG_APPROACH:   cfg_q.approach_step_mm   <= wr_data[10:0];
				REG_CLIFF_JUMP: cfg_q.cliff_jump_mm      <= wr_data[10:0];
				REG_GRACE:      cfg_q.grace_ticks        <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/tcog_decide.sv @@
// stop decision for one poll tick and the next per-move state
// purely combinational; uses tcog_pkg
module tcog_decide (
	input  tcog_pkg::cfg_t    cfg,
	input  tcog_pkg::state_t  st,
	input  tcog_pkg::item_t   itm,
	output tcog_pkg::state_t  nst,
	output tcog_pkg::reason_t reason
);
	import tcog_pkg::*;

	function automatic logic [12:0] abs_diff(input logic [12:0] a, input logic [12:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [3:0] sat_inc(input logic [3:0] v);
		return (v != 4'hF) ? v + 4'd1 : v;
	endfunction

	// unusable sample: far, lost or nothing
	function automatic reason_t cliff_inv(input logic valid, input logic [12:0] d,
		input logic [12:0] far, input logic [12:0] near, input logic [12:0] maxv);
		reason_t r;
		if (d != 13'd0 && d < near)
			r = RSN_NONE;
		else if (valid && d >= maxv)
			r = RSN_FAR;
		else if (!valid || d == 13'd0)
			r = RSN_LOST;
		else if (d > far)
			r = RSN_FAR;
		else
			r = RSN_NONE;
		return r;
	endfunction

	logic    f_usable;
	logic    r_usable;
	logic    front_armed;
	logic    grace;
	logic [12:0] fd;
	logic [12:0] cal13;
	logic [12:0] obs13;
	logic [13:0] jump_lim;
	reason_t rsn_cal;
	reason_t rsn_fb;
	state_t  mid;

	assign fd          = itm.front_distance;
	assign cal13       = 13'(cfg.cal_ref_mm);
	assign obs13       = 13'(cfg.obstacle_stop_mm);
	assign f_usable    = itm.front_valid && fd != 13'd0 && fd <= cfg.max_valid_mm;
	assign r_usable    = itm.rear_valid && itm.rear_distance != 13'd0 &&
		itm.rear_distance <= cfg.max_valid_mm;
	assign front_armed = !(itm.left_reverse && itm.right_reverse);

	// movement start and end, tick count, streak and move minimum
	always_comb begin
		mid   = st;
		grace = 1'b0;
		if (itm.moving != st.in_motion) begin
			mid.last_distance  = 13'd0;
			mid.last_valid     = 1'b0;
			mid.least_distance = 13'd0;
			mid.least_valid    = 1'b0;
			if (itm.moving) begin
				mid.ticks_since_start = 8'd0;
				mid.fail_streak       = 4'd0;
				if (itm.front_fresh && f_usable) begin
					mid.last_distance  = fd;
					mid.last_valid     = 1'b1;
					mid.least_distance = fd;
					mid.least_valid    = 1'b1;
				end
			end
			mid.in_motion = itm.moving;
		end else if (itm.moving && mid.ticks_since_start != 8'hFF) begin
			mid.ticks_since_start = mid.ticks_since_start + 8'd1;
		end
		if (itm.moving) begin
			grace = mid.ticks_since_start < cfg.grace_ticks;
			if (!itm.front_fresh) begin
				if (!grace)
					mid.fail_streak = sat_inc(mid.fail_streak);
			end else if (f_usable) begin
				mid.fail_streak = 4'd0;
			end
			if (itm.front_fresh && f_usable && (!mid.least_valid || fd < mid.least_distance)) begin
				mid.least_distance = fd;
				mid.least_valid    = 1'b1;
			end
		end
	end

	assign jump_lim = {1'b0, mid.least_distance} + 14'(cfg.cliff_jump_mm);

	// front check against calibrated limits
	always_comb begin
		if (f_usable) begin
			if (fd < cfg.near_mm)
				rsn_cal = RSN_OBSTACLE;
			else if (mid.last_valid && mid.last_distance >= cfg.near_mm &&
				({1'b0, fd} + 14'(cfg.approach_step_mm)) <= {1'b0, mid.last_distance})
				rsn_cal = RSN_OBSTACLE;
			else if (mid.least_valid && {1'b0, fd} >= jump_lim)
				rsn_cal = RSN_JUMP;
			else if (fd > cfg.far_mm)
				rsn_cal = RSN_FAR;
			else if (mid.last_valid && {1'b0, abs_diff(fd, cal13)} >=
				({1'b0, abs_diff(mid.last_distance, cal13)} + 14'(DEVIATION_JUMP_MM)))
				rsn_cal = RSN_JUMP;
			else
				rsn_cal = RSN_NONE;
		end else if (fd != 13'd0 && fd < cfg.near_mm) begin
			rsn_cal = RSN_OBSTACLE;
		end else if (mid.last_valid && abs_diff(mid.last_distance, cal13) <= cfg.far_mm) begin
			rsn_cal = RSN_LOST;
		end else begin
			rsn_cal = cliff_inv(itm.front_valid, fd, cfg.far_mm, cfg.near_mm, cfg.max_valid_mm);
		end
	end

	// front check against fixed thresholds
	always_comb begin
		if (f_usable) begin
			if (fd <= obs13)
				rsn_fb = RSN_OBSTACLE;
			else if (mid.least_valid && {1'b0, fd} >= jump_lim)
				rsn_fb = RSN_JUMP;
			else if (fd >= cfg.cliff_void_mm)
				rsn_fb = RSN_FAR;
			else
				rsn_fb = RSN_NONE;
		end else if (mid.last_valid && mid.last_distance <= 13'(CLIFF_NEAR_MAX_MM) &&
			mid.last_distance > obs13) begin
			rsn_fb = RSN_LOST;
		end else begin
			rsn_fb = cliff_inv(itm.front_valid, fd, cfg.cliff_void_mm, obs13, cfg.max_valid_mm);
		end
	end

	// decision after grace unless both wheels reverse, rear floor check and clearing on a stop
	always_comb begin
		nst    = mid;
		reason = RSN_NONE;
		if (itm.moving && !grace && front_armed) begin
			if (itm.front_fresh) begin
				reason = (cfg.cal_ref_mm != 11'd0) ? rsn_cal : rsn_fb;
				if (f_usable) begin
					nst.last_distance = fd;
					nst.last_valid    = 1'b1;
				end else if (reason == RSN_NONE) begin
					nst.fail_streak = sat_inc(nst.fail_streak);
				end
			end else if (nst.fail_streak >= LOST_STREAK) begin
				reason = RSN_LOST;
			end else if (nst.fail_streak >= OBST_STREAK) begin
				reason = RSN_OBSTACLE;
			end else begin
				nst.fail_streak = sat_inc(nst.fail_streak);
			end
			if (reason == RSN_NONE && itm.rear_fresh &&
				(!r_usable || itm.rear_distance > 13'(cfg.cliff_floor_max_mm)))
				reason = RSN_FLOOR;
			if (reason != RSN_NONE) begin
				nst.in_motion         = 1'b0;
				nst.ticks_since_start = 8'd0;
				nst.fail_streak       = 4'd0;
				nst.last_distance     = 13'd0;
				nst.last_valid        = 1'b0;
				nst.least_distance    = 13'd0;
				nst.least_valid       = 1'b0;
			end
		end
	end

endmodule

@@ sv/tof_cliff_obstacle_guard_core.sv @@
// top level of the front/rear range guard: input register, decision, result register
// depends on tcog_pkg, tcog_cfg_regs and tcog_decide
//
// usage
// - s_axis carries one poll tick per word: motor state and front and rear range samples
// - m_axis returns one word per tick: the stop flag and the stop reason code
// - cfg writes one of eight registers (index 0..7) per handshake; cfg_ready is always high;
//   the user must write registers only while no tick is in flight; the block does not enforce it
// - path: the result of an accepted word passes the input register and then the result
//   register before it is valid on m_axis
// - throughput: one word per cycle while m_axis is not stalled; the decision is one pass of
//   compare logic between the input register and the result register, and the per-move state
//   updates as each word leaves the input register, so the next word sees it at once
// - stall: when m_axis_tready is low the result is held; one more word waits in the
//   input register, then s_axis_tready drops until the result is taken
// - reset: registers return to their defaults (uncalibrated, fixed thresholds), the
//   move state is cleared and both registers are empty; no clearing pass is needed
module tof_cliff_obstacle_guard_core (
	input  logic        clk,
	input  logic        arst_n,
	// moving, left_reverse, right_reverse, front_fresh, front_valid, front_distance[12:0],
	// rear_fresh, rear_valid, rear_distance[12:0], zero pad
	input  logic [39:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// stop, stop_reason[2:0], zero pad
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import tcog_pkg::*;

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	state_t  st_q;
	state_t  nst;
	reason_t reason;
	reason_t reason_q;
	logic    out_valid_q;
	logic    advance;
	logic    in_accept;

	assign cfg_ready = 1'b1;

	tcog_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// unpack the input word
	always_comb begin
		item_in.moving         = s_axis_tdata[0];
		item_in.left_reverse   = s_axis_tdata[1];
		item_in.right_reverse  = s_axis_tdata[2];
		item_in.front_fresh    = s_axis_tdata[3];
		item_in.front_valid    = s_axis_tdata[4];
		item_in.front_distance = s_axis_tdata[17:5];
		item_in.rear_fresh     = s_axis_tdata[18];
		item_in.rear_valid     = s_axis_tdata[19];
		item_in.rear_distance  = s_axis_tdata[32:20];
	end

	// handshake between input register and result register
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			item_s1 <= item_in;
	end

	tcog_decide u_decide (
		.cfg    (cfg),
		.st     (st_q),
		.itm    (item_s1),
		.nst    (nst),
		.reason (reason)
	);

	// per-move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= nst;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			reason_q <= reason;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, reason_q, reason_q != RSN_NONE};

	// a stop leaves the move state cleared
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && reason != RSN_NONE) |=>
		(!st_q.in_motion && st_q.fail_streak == 4'd0 && !st_q.last_valid &&
		!st_q.least_valid))
		else $error("move state not cleared after stop");

	// the move minimum never exceeds the previous usable distance
	a_least_le_last: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.last_valid |-> (st_q.least_valid && st_q.least_distance <= st_q.last_distance))
		else $error("move minimum above previous distance");

	// no stop is decided while the motor is not moving
	a_idle_no_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !item_s1.moving) |-> (reason == RSN_NONE))
		else $error("stop decided while not moving");

	// a result is loaded into the result register as the word leaves the input register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_axis_tvalid && m_axis_tdata[3:1] == $past(reason)))
		else $error("result word lost");

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking bench for the front/rear range guard: directed ticks, then random moves
// depends on tcog_pkg and tof_cliff_obstacle_guard_core; predicts untyped ticks' stops itself
`timescale 1ns / 100ps

module tb_top;
	import tcog_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_TICKS = 150;

	typedef struct {
		logic    stop;
		reason_t reason;
	} verdict_t;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  idx;
		logic [12:0] val;
		logic [39:0] word;
		int          reps;
		bit          typed;
		reason_t     rsn;
	} guard_row_t;

	logic        clk;
	logic        arst_n;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [12:0] cfg_data;

	verdict_t   due_verdicts[$];
	guard_row_t stim_rows[$];
	int         fail_count  = 0;
	int         cycle_count = 0;
	int         ticks_sent  = 0;
	int         burst_left  = 0;

	// register copy, reset values
	int lim_cal       = 0;
	int lim_max_valid = 2000;
	int lim_obst      = 120;
	int lim_void      = 400;
	int lim_floor     = 60;
	int lim_approach  = 30;
	int lim_jump      = 100;
	int lim_grace     = 5;

	// per-move tracking copy
	bit move_active = 0;
	int move_ticks  = 0;
	int prev_mm     = 0;
	bit prev_ok     = 0;
	int least_mm    = 0;
	bit least_ok    = 0;
	int miss_streak = 0;

	tof_cliff_obstacle_guard_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle count and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL tof_cliff_obstacle_guard_core");
			$finish;
		end
	end

	// tick word: fields packed from bit 0 up
	function automatic logic [39:0] tick_word(input logic mv, input logic lr, input logic rr,
			input logic ff, input logic fv, input logic [12:0] fd,
			input logic rf, input logic rv, input logic [12:0] rd);
		return {7'b0, rd, rv, rf, fd, fv, ff, rr, lr, mv};
	endfunction

	function automatic guard_row_t trow(input logic [39:0] w, input int reps,
			input bit typed, input reason_t rsn);
		guard_row_t r;
		r = '{0, REG_CAL_REF, 13'd0, w, reps, typed, rsn};
		return r;
	endfunction

	function automatic guard_row_t crow(input logic [2:0] idx, input logic [12:0] val);
		guard_row_t r;
		r = '{1, idx, val, 40'd0, 0, 0, RSN_NONE};
		return r;
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [12:0] val);
		case (idx)
			REG_CAL_REF:    lim_cal       = int'(val[10:0]);
			REG_MAX_VALID:  lim_max_valid = int'(val);
			REG_OBST_STOP:  lim_obst      = int'(val[10:0]);
			REG_CLIFF_VOID: lim_void      = int'(val);
			REG_FLOOR_MAX:  lim_floor     = int'(val[10:0]);
			REG_APPROACH:   lim_approach  = int'(val[10:0]);
			REG_CLIFF_JUMP: lim_jump      = int'(val[10:0]);
			REG_GRACE:      lim_grace     = int'(val[7:0]);
			default: ;
		endcase
	endfunction

	function automatic bit sample_ok(input logic valid, input int d);
		return valid && d > 0 && d <= lim_max_valid;
	endfunction

	function automatic int dist_gap(input int a, input int b);
		return a >= b ? a - b : b - a;
	endfunction

	function automatic void bump_streak();
		if (miss_streak < 15)
			miss_streak++;
	endfunction

	function automatic void clear_track();
		prev_mm  = 0;
		prev_ok  = 0;
		least_mm = 0;
		least_ok = 0;
	endfunction

	// unusable sample outside the near band: far, lost or nothing
	function automatic reason_t fringe_cliff(input logic valid, input int d,
			input int far_mm, input int near_mm);
		if (d > 0 && d < near_mm)
			return RSN_NONE;
		if (valid && d >= lim_max_valid)
			return RSN_FAR;
		if (!valid || d == 0)
			return RSN_LOST;
		if (d > far_mm)
			return RSN_FAR;
		return RSN_NONE;
	endfunction

	// one poll tick through the guard: updates the tracking copy, returns the stop reason
	function automatic reason_t stop_decision(input logic [39:0] w);
		logic    mv, lrev, rrev, ffr, fval, rfr, rval;
		int      fd, rd, near_mm, far_mm, prev;
		bit      fok, in_grace;
		reason_t rsn;
		mv   = w[0];
		lrev = w[1];
		rrev = w[2];
		ffr  = w[3];
		fval = w[4];
		fd   = int'(w[17:5]);
		rfr  = w[18];
		rval = w[19];
		rd   = int'(w[32:20]);
		fok  = sample_ok(fval, fd);
		rsn  = RSN_NONE;

		// start and end of a move
		if (mv != move_active) begin
			clear_track();
			if (mv) begin
				move_ticks  = 0;
				miss_streak = 0;
				if (ffr && fok) begin
					prev_mm  = fd;
					prev_ok  = 1;
					least_mm = fd;
					least_ok = 1;
				end
			end
			move_active = mv;
		end else if (mv && move_ticks < 255) begin
			move_ticks++;
		end

		if (mv) begin
			in_grace = move_ticks < lim_grace;
			if (!ffr) begin
				if (!in_grace)
					bump_streak();
			end else if (fok) begin
				miss_streak = 0;
			end
			if (ffr && fok && (!least_ok || fd < least_mm)) begin
				least_mm = fd;
				least_ok = 1;
			end

			if (!in_grace && !(lrev && rrev)) begin
				if (ffr) begin
					prev = prev_mm;
					if (lim_cal != 0) begin
						// calibrated near and far limits
						near_mm = lim_cal * (100 - NEAR_MARGIN_PCT) / 100;
						if (lim_cal - NEAR_MARGIN_MM > near_mm)
							near_mm = lim_cal - NEAR_MARGIN_MM;
						far_mm = lim_cal * (100 + FAR_MARGIN_PCT) / 100;
						if (lim_cal + FAR_MARGIN_MM < far_mm)
							far_mm = lim_cal + FAR_MARGIN_MM;
						if (fok) begin
							if (fd < near_mm)
								rsn = RSN_OBSTACLE;
							else if (prev_ok && prev >= near_mm && fd <= prev - lim_approach)
								rsn = RSN_OBSTACLE;
							else if (least_ok && fd >= least_mm + lim_jump)
								rsn = RSN_JUMP;
							else if (fd > far_mm)
								rsn = RSN_FAR;
							else if (prev_ok && dist_gap(fd, lim_cal) >=
									dist_gap(prev, lim_cal) + DEVIATION_JUMP_MM)
								rsn = RSN_JUMP;
						end else if (fd > 0 && fd < near_mm) begin
							rsn = RSN_OBSTACLE;
						end else if (prev_ok && dist_gap(prev, lim_cal) <= far_mm) begin
							rsn = RSN_LOST;
						end else begin
							rsn = fringe_cliff(fval, fd, far_mm, near_mm);
						end
					end else begin
						// fixed thresholds
						if (fok) begin
							if (fd <= lim_obst)
								rsn = RSN_OBSTACLE;
							else if (least_ok && fd >= least_mm + lim_jump)
								rsn = RSN_JUMP;
							else if (fd >= lim_void)
								rsn = RSN_FAR;
						end else if (prev_ok && prev <= CLIFF_NEAR_MAX_MM && prev > lim_obst) begin
							rsn = RSN_LOST;
						end else begin
							rsn = fringe_cliff(fval, fd, lim_void, lim_obst);
						end
					end
					if (fok) begin
						prev_mm = fd;
						prev_ok = 1;
					end else if (rsn == RSN_NONE) begin
						bump_streak();
					end
				end else if (miss_streak >= LOST_STREAK) begin
					rsn = RSN_LOST;
				end else if (miss_streak >= OBST_STREAK) begin
					// shadowed by the lost signal case
					rsn = RSN_OBSTACLE;
				end else begin
					bump_streak();
				end

				// rear floor sample
				if (rsn == RSN_NONE && rfr) begin
					if (!sample_ok(rval, rd) || rd > lim_floor)
						rsn = RSN_FLOOR;
				end
				if (rsn != RSN_NONE) begin
					move_active = 0;
					move_ticks  = 0;
					miss_streak = 0;
					clear_track();
				end
			end
		end
		return rsn;
	endfunction

	// send one tick word in bursts with random gaps, predict on acceptance
	task automatic send_tick(input logic [39:0] w, input bit typed, input reason_t rsn);
		int       gap;
		verdict_t v;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		s_axis_tdata  = w;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		v.reason = stop_decision(w);
		if (typed)
			v.reason = rsn;
		v.stop = (v.reason != RSN_NONE);
		due_verdicts.push_back(v);
		ticks_sent++;
	endtask

	// stop sending and wait until every result has come back
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (due_verdicts.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver stalls, with a random pattern picked anew at the end of each run
	int stall_mode = 0;
	int mode_left  = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(20, 120);
		end
		mode_left--;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ((cycle_count % 7) < 4);
		endcase
	end

	// result checker
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_verdicts.size() == 0) begin
				$error("result word with no tick outstanding: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = due_verdicts.pop_front();
				if (m_axis_tdata[0] !== want.stop) begin
					$error("stop mismatch: expected %0d, actual %0d", want.stop, m_axis_tdata[0]);
					fail_count++;
				end
				if (m_axis_tdata[3:1] !== want.reason) begin
					$error("stop_reason mismatch: expected %0d, actual %0d",
						want.reason, m_axis_tdata[3:1]);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int      p, i, len, base, d, rd, start_ticks;
		bit      both_rev;
		int      cfg_vals[8];
		logic    ff, fv, rf, rv, lr, rr;

		s_axis_tdata  = '0;
		s_axis_tvalid = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_CAL_REF;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed ticks, fixed thresholds first
		stim_rows.push_back(trow(tick_word(0, 0, 0, 0, 0, 0, 0, 0, 0), 2, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(0, 1, 1, 1, 1, 8191, 1, 1, 8191), 1, 1, RSN_NONE));
		// move start and grace period
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 300, 1, 1, 30), 5, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 1, 0, 1, 1, 300, 1, 1, 30), 1, 0, RSN_NONE));
		// rise over the move minimum
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 400, 0, 0, 0), 1, 0, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 300, 0, 0, 0), 5, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 120, 0, 0, 0), 1, 1, RSN_OBSTACLE));
		// both wheels reversing: no decision while the miss streak saturates
		stim_rows.push_back(trow(tick_word(1, 1, 1, 0, 0, 0, 0, 0, 0), 21, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, RSN_LOST));
		// missing front sample counts twice per tick
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 300, 0, 0, 0), 5, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 0, 0, 0, 0, 0, 0), 3, 0, RSN_NONE));
		// invalid sample just after a near reading
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 180, 0, 0, 0), 5, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 0, 180, 0, 0, 0), 1, 0, RSN_NONE));
		// largest distance
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 300, 0, 0, 0), 5, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 8191, 0, 0, 0), 1, 0, RSN_NONE));
		// move end, then rear floor sample invalid
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 300, 0, 0, 0), 5, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(0, 0, 0, 1, 1, 300, 0, 0, 0), 1, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 300, 1, 0, 30), 5, 1, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 300, 1, 0, 30), 1, 1, RSN_FLOOR));
		// calibrated, no grace
		stim_rows.push_back(crow(REG_CAL_REF, 13'd300));
		stim_rows.push_back(crow(REG_GRACE, 13'd0));
		stim_rows.push_back(trow(tick_word(1, 0, 1, 1, 1, 300, 1, 1, 30), 1, 0, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 270, 0, 0, 0), 1, 0, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 1, 250, 0, 0, 0), 1, 0, RSN_NONE));
		stim_rows.push_back(trow(tick_word(1, 0, 0, 1, 0, 0, 0, 0, 0), 1, 0, RSN_NONE));

		foreach (stim_rows[r]) begin
			if (stim_rows[r].is_cfg) begin
				settle();
				write_reg(stim_rows[r].idx, stim_rows[r].val);
			end else begin
				repeat (stim_rows[r].reps)
					send_tick(stim_rows[r].word, stim_rows[r].typed, stim_rows[r].rsn);
			end
		end

		// random moves under a run of register settings
		for (p = 0; p < 10; p++) begin
			case (p)
				0: cfg_vals = '{0, 2000, 120, 400, 60, 30, 100, 5};
				1: cfg_vals = '{0, 0, 0, 0, 0, 0, 0, 0};
				2: cfg_vals = '{2047, 8191, 2047, 8191, 2047, 2047, 2047, 255};
				3: cfg_vals = '{300, 2000, 120, 400, 60, 30, 100, 3};
				4: cfg_vals = '{2000, 8191, 120, 400, 200, 50, 150, 2};
				5: cfg_vals = '{1, 2000, 120, 400, 60, 30, 100, 0};
				default: begin
					cfg_vals[0] = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8191);
					cfg_vals[1] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
						: $urandom_range(200, 2500);
					cfg_vals[2] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
						: $urandom_range(0, 400);
					cfg_vals[3] = $urandom_range(0, 8191);
					cfg_vals[4] = $urandom_range(0, 300);
					cfg_vals[5] = $urandom_range(0, 100);
					cfg_vals[6] = $urandom_range(0, 300);
					cfg_vals[7] = $urandom_range(0, 12);
				end
			endcase
			settle();
			for (i = 0; i < 8; i++)
				write_reg(i[2:0], cfg_vals[i][12:0]);

			start_ticks = ticks_sent;
			while (ticks_sent - start_ticks < PHASE_TICKS) begin
				if ($urandom_range(0, 99) < 15) begin
					// noise: any word at all
					send_tick({7'b0, 1'($urandom_range(0, 1)), 32'($urandom())}, 0, RSN_NONE);
				end else begin
					// one move: a drifting front distance near some threshold
					len = (lim_grace > 20) ? lim_grace + $urandom_range(2, 30)
						: $urandom_range(lim_grace + 1, lim_grace + 30);
					if (lim_cal != 0) begin
						base = lim_cal;
					end else begin
						case ($urandom_range(0, 3))
							0: base = lim_obst;
							1: base = lim_void;
							2: base = CLIFF_NEAR_MAX_MM;
							default: base = $urandom_range(1, lim_max_valid);
						endcase
					end
					base = base + $urandom_range(0, 160) - 80;
					both_rev = ($urandom_range(0, 7) == 0);
					for (i = 0; i < len; i++) begin
						if ($urandom_range(0, 9) == 0)
							base = base - $urandom_range(0, 40);
						d = base + $urandom_range(0, 20) - 10;
						if ($urandom_range(0, 11) == 0)
							d = $urandom_range(0, 8191);
						if ($urandom_range(0, 29) == 0)
							d = 0;
						if (d < 0)
							d = 0;
						if (d > 8191)
							d = 8191;
						rd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
							: $urandom_range(0, lim_floor + 2);
						if (rd > 8191)
							rd = 8191;
						ff = ($urandom_range(0, 15) != 0);
						fv = ($urandom_range(0, 15) != 0);
						rf = 1'($urandom_range(0, 1));
						rv = ($urandom_range(0, 15) != 0);
						lr = both_rev || ($urandom_range(0, 3) == 0);
						rr = both_rev || ($urandom_range(0, 3) == 0);
						send_tick(tick_word(1, lr, rr, ff, fv, d[12:0], rf, rv, rd[12:0]),
							0, RSN_NONE);
					end
					repeat ($urandom_range(1, 3))
						send_tick({7'b0, 32'($urandom()), 1'b0}, 0, RSN_NONE);
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS tof_cliff_obstacle_guard_core");
		else
			$display("FAIL tof_cliff_obstacle_guard_core");
		$finish;
	end

endmodule

@@ files.f @@
sv/tcog_pkg.sv
sv/tcog_cfg_regs.sv
sv/tcog_decide.sv
sv/tof_cliff_obstacle_guard_core.sv
tb/sv/tb_top.sv
